FILE: design/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Types, widths, constants and the microprogram for the cosine series block.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int ANGLE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int OUT_W      = 48;
  localparam int FRAC_BITS  = 28;
  localparam int RECIP_BITS = 32;

  localparam int MAG_W   = 32;                    // |x|, Q4.28 magnitude
  localparam int X2_W    = 35;                    // x^2, Q7.28
  localparam int HALF_W  = 18;                    // multiplier B slice
  localparam int B_W     = 2 * HALF_W;            // B operand, holds the factor
  localparam int TERM_W  = 40;                    // term magnitude, Q12.28
  localparam int A_W     = TERM_W;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = 50;
  localparam int IDX_W   = $clog2(MAX_TERMS);
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);
  localparam int PC_W    = 4;

  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic        [COUNT_W-1:0] term_count;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] approximation;
    logic                    saturated;
  } result_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_WR_X2,
    OP_WR_F,
    OP_WR_TERM,
    OP_ACC,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    A_MAG,
    A_X2,
    A_TERM
  } asel_t;

  typedef enum logic [1:0] {
    B_MAG,
    B_RECIP,
    B_FACTOR
  } bsel_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_IF_ZERO,
    J_IF_LAST
  } jmp_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    bsel_t bsel;
    jmp_t  jmp;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic count_zero;
    logic last_term;
  } flags_t;

  // Program addresses
  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_SQ_LO = 4'd1;
  localparam pc_t PC_SQ_HI = 4'd2;
  localparam pc_t PC_SQ_WR = 4'd3;
  localparam pc_t PC_ACC   = 4'd4;
  localparam pc_t PC_F_LO  = 4'd5;
  localparam pc_t PC_F_HI  = 4'd6;
  localparam pc_t PC_F_WR  = 4'd7;
  localparam pc_t PC_T_LO  = 4'd8;
  localparam pc_t PC_T_HI  = 4'd9;
  localparam pc_t PC_T_WR  = 4'd10;
  localparam pc_t PC_DONE  = 4'd11;

  // Microprogram: one control word per step
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, asel: A_MAG, bsel: B_MAG, jmp: J_NEXT, target: PC_IDLE};
    case (pc)
      PC_SQ_LO: w = '{op: OP_MUL_LO, asel: A_MAG, bsel: B_MAG,
                      jmp: J_IF_ZERO, target: PC_DONE};
      PC_SQ_HI: w = '{op: OP_MUL_HI, asel: A_MAG, bsel: B_MAG,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_SQ_WR: w = '{op: OP_WR_X2, asel: A_MAG, bsel: B_MAG,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_ACC:   w = '{op: OP_ACC, asel: A_MAG, bsel: B_MAG,
                      jmp: J_IF_LAST, target: PC_DONE};
      PC_F_LO:  w = '{op: OP_MUL_LO, asel: A_X2, bsel: B_RECIP,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_F_HI:  w = '{op: OP_MUL_HI, asel: A_X2, bsel: B_RECIP,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_F_WR:  w = '{op: OP_WR_F, asel: A_X2, bsel: B_RECIP,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_T_LO:  w = '{op: OP_MUL_LO, asel: A_TERM, bsel: B_FACTOR,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_T_HI:  w = '{op: OP_MUL_HI, asel: A_TERM, bsel: B_FACTOR,
                      jmp: J_NEXT, target: PC_IDLE};
      PC_T_WR:  w = '{op: OP_WR_TERM, asel: A_TERM, bsel: B_FACTOR,
                      jmp: J_ALWAYS, target: PC_ACC};
      PC_DONE:  w = '{op: OP_DONE, asel: A_MAG, bsel: B_MAG,
                      jmp: J_ALWAYS, target: PC_IDLE};
      default:  w = '{op: OP_NOP, asel: A_MAG, bsel: B_MAG,
                      jmp: J_ALWAYS, target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Q0.32 reciprocal of (2i-1)(2i), rounded to nearest
  function automatic logic [RECIP_BITS-1:0] recip(input logic [IDX_W-1:0] i);
    logic [RECIP_BITS-1:0] r;
    case (i)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd357913941;
      4'd3:    r = 32'd143165577;
      4'd4:    r = 32'd76695845;
      4'd5:    r = 32'd47721859;
      4'd6:    r = 32'd32537631;
      4'd7:    r = 32'd23598721;
      4'd8:    r = 32'd17895697;
      4'd9:    r = 32'd14035841;
      4'd10:   r = 32'd11302546;
      4'd11:   r = 32'd9296466;
      4'd12:   r = 32'd7780738;
      4'd13:   r = 32'd6607642;
      4'd14:   r = 32'd5681174;
      4'd15:   r = 32'd4936744;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/cts_sequencer.sv
// ----------------------------------------------------------------------------
// cts_sequencer
// Step counter over the microprogram, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module cts_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cts_pkg::flags_t flags,
  output cts_pkg::ctrl_t ctrl,
  output logic           busy
);
  import cts_pkg::*;

  pc_t pc;
  pc_t pc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc + 1'b1;
    if (pc == PC_IDLE) begin
      pc_next = start ? PC_SQ_LO : PC_IDLE;
    end else begin
      case (ctrl.jmp)
        J_NEXT:    pc_next = pc + 1'b1;
        J_ALWAYS:  pc_next = ctrl.target;
        J_IF_ZERO: pc_next = flags.count_zero ? ctrl.target : pc + 1'b1;
        J_IF_LAST: pc_next = flags.last_term ? ctrl.target : pc + 1'b1;
        default:   pc_next = PC_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl = ucode(pc);
    busy = (pc != PC_IDLE);
  end

  // the program ends by returning to idle, from nowhere else
  a_idle_from_done: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_IDLE) && $past(pc != PC_IDLE) |-> $past(pc == PC_DONE))
    else $error("sequencer reached idle from a step other than done");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_DONE)
    else $error("step counter beyond the program");

endmodule

FILE: design/cts_datapath.sv
// ----------------------------------------------------------------------------
// cts_datapath
// Operand registers, one shared 40x18 multiplier with a product register,
// rounding write-back, signed accumulator and the result register.
// ----------------------------------------------------------------------------
module cts_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cts_pkg::item_t   item,
  input  cts_pkg::ctrl_t   ctrl,
  output cts_pkg::flags_t  flags,
  output cts_pkg::result_t result,
  output logic             done
);
  import cts_pkg::*;

  logic        [MAG_W-1:0]  mag;
  logic        [X2_W-1:0]   x2;
  logic        [B_W-1:0]    factor;
  logic        [TERM_W-1:0] term;
  logic        [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic        [CNT_W-1:0]  n;
  logic        [CNT_W-1:0]  i;

  logic        [A_W-1:0]          a_op;
  logic        [B_W-1:0]          b_op;
  logic        [HALF_W-1:0]       b_half;
  logic        [A_W+HALF_W-1:0]   mul;
  logic        [PROD_W-1:0]       rnd_frac;
  logic        [PROD_W-1:0]       rnd_recip;
  logic signed [ACC_W-1:0]        term_ext;
  logic                           over_hi;
  logic                           over_lo;

  always_comb begin
    case (ctrl.asel)
      A_MAG:   a_op = A_W'(mag);
      A_X2:    a_op = A_W'(x2);
      A_TERM:  a_op = term;
      default: a_op = '0;
    endcase
    case (ctrl.bsel)
      B_MAG:    b_op = B_W'(mag);
      B_RECIP:  b_op = B_W'(recip(i[IDX_W-1:0]));
      B_FACTOR: b_op = factor;
      default:  b_op = '0;
    endcase
    b_half    = (ctrl.op == OP_MUL_HI) ? b_op[B_W-1:HALF_W] : b_op[HALF_W-1:0];
    mul       = a_op * b_half;
    rnd_frac  = (prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_recip = (prod + (PROD_W'(1) << (RECIP_BITS - 1))) >> RECIP_BITS;
    term_ext  = $signed({{(ACC_W-TERM_W){1'b0}}, term});
    over_hi   = (acc > OUT_MAX);
    over_lo   = (acc < OUT_MIN);
    flags.count_zero = (n == '0);
    flags.last_term  = ((i + 1'b1) == n);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag  <= item.angle[ANGLE_W-1] ? MAG_W'(0) - $unsigned(item.angle)
                                    : $unsigned(item.angle);
      n    <= (item.term_count > COUNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                      : CNT_W'(item.term_count);
      term <= TERM_W'(1) << FRAC_BITS;
      acc  <= '0;
      i    <= '0;
    end else begin
      case (ctrl.op)
        OP_MUL_LO:  prod   <= PROD_W'(mul);
        OP_MUL_HI:  prod   <= prod + (PROD_W'(mul) << HALF_W);
        OP_WR_X2:   x2     <= rnd_frac[X2_W-1:0];
        OP_WR_F:    factor <= rnd_recip[B_W-1:0];
        OP_WR_TERM: term   <= rnd_frac[TERM_W-1:0];
        OP_ACC: begin
          // odd terms carry the minus sign
          acc <= i[0] ? acc - term_ext : acc + term_ext;
          i   <= i + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // done strobe, high for one cycle, marks the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_DONE) begin
      result.saturated <= over_hi || over_lo;
      if (over_hi) begin
        result.approximation <= OUT_MAX[OUT_W-1:0];
      end else if (over_lo) begin
        result.approximation <= OUT_MIN[OUT_W-1:0];
      end else begin
        result.approximation <= acc[OUT_W-1:0];
      end
    end
  end

  a_hi_after_lo: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_MUL_HI |-> $past(ctrl.op == OP_MUL_LO))
    else $error("upper partial product without the lower one");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_ACC |-> i < n)
    else $error("more terms summed than requested");

endmodule

FILE: design/cosine_taylor_series.sv
// ----------------------------------------------------------------------------
// cosine_taylor_series
// Truncated Maclaurin cosine in fixed point, run by a microcoded sequencer.
//
//   channel  ports                  direction  payload
//   item     start / busy / item    in         angle Q4.28, term_count
//   result   done / result          out        approximation Q20.28, saturated
//
// An item is taken at an edge with start high and busy low; busy then stays
// high until the run returns to idle (no terms are run when the count is
// zero), and done marks the result in the cycle in which busy falls. Each
// term costs two multiplications of three steps each on the one shared
// 40x18 multiplier, which sets the rate. The next item may start in the
// cycle that shows the result. The receiver cannot stall. Synchronous
// reset returns the sequencer to idle and clears done.
// ----------------------------------------------------------------------------
module cosine_taylor_series (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cts_pkg::item_t   item,
  output logic             busy,
  output cts_pkg::result_t result,
  output logic             done
);
  import cts_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   load;

  assign load = start && !busy;

  cts_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  cts_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .item   (item),
    .ctrl   (ctrl),
    .flags  (flags),
    .result (result),
    .done   (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not start the sequencer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a run");

  a_sat_ends: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      (result.approximation == OUT_MAX[OUT_W-1:0]) ||
      (result.approximation == OUT_MIN[OUT_W-1:0]))
    else $error("saturated result not at a range end");

endmodule
